@@ hdl/pel_pkg.sv @@
// Shared constants and types for the lattice energy engine.
// Depends on nothing; used by potts_lattice_energy and pel_checker.
package pel_pkg;

	localparam int GRID_DIM  = 64;
	localparam int MAX_CELLS = 256;

	localparam int COORD_W   = $clog2(GRID_DIM);
	localparam int LAT_DEPTH = GRID_DIM * GRID_DIM;
	localparam int LAT_AW    = $clog2(LAT_DEPTH);
	localparam int CELL_AW   = $clog2(MAX_CELLS);
	localparam int CNT_W     = $clog2(MAX_CELLS + 1);
	localparam int CLR_DEPTH = (LAT_DEPTH > MAX_CELLS) ? LAT_DEPTH : MAX_CELLS;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	localparam int ACC_W = 64;
	localparam int E_W   = 52;

	localparam int CFG_W = 13;

	localparam int MOORE_DX [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
	localparam int MOORE_DY [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

	typedef enum logic [1:0] {
		OP_SITE_WR = 2'd0,
		OP_CELL_WR = 2'd1,
		OP_LOCAL   = 2'd2,
		OP_TOTAL   = 2'd3
	} op_t;

	typedef enum logic {
		REG_TARGET_AREA  = 1'b0,
		REG_CELLS_IN_USE = 1'b1
	} reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAIR,
		ST_PAIR_WAIT,
		ST_AREA,
		ST_AREA_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [15:0] adhesion;
		logic [15:0]        weight;
		logic [12:0]        size;
	} cell_rec_t;

endpackage

@@ hdl/potts_lattice_energy.sv @@
// Top level of the lattice energy engine: lattice and cell record memories,
// sequencer, pair and area datapaths. Depends on pel_pkg.
//
// Cellular Potts energy engine. After reset the block runs a clearing pass
// over both memories, one entry a cycle, across max(GRID_DIM*GRID_DIM,
// MAX_CELLS) entries (4096 here), and stalls its input until that is done;
// configuration writes are taken throughout. Site and cell writes leave the
// input free. A local query reads the centre and its eight wrapped neighbours
// through the single lattice read port, then walks the cell records in use
// through the cell memory read port and a square and multiply pipeline
// (cells_in_use capped at MAX_CELLS). A total query repeats the site walk for
// every site before the area walk. A result sits in an output register, so
// the next item is taken while it waits for its transfer.
module potts_lattice_energy (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [12:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	input  logic [5:0]          pos_x,
	input  logic [5:0]          pos_y,
	input  logic [7:0]          cell_index,
	input  logic signed [15:0]  adhesion,
	input  logic [15:0]         area_weight,
	input  logic [12:0]         cell_area,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [51:0]  energy
);

	localparam logic signed [pel_pkg::ACC_W-1:0] E_MAX =
		{{(pel_pkg::ACC_W - pel_pkg::E_W + 1){1'b0}}, {(pel_pkg::E_W - 1){1'b1}}};
	localparam logic signed [pel_pkg::ACC_W-1:0] E_MIN = ~E_MAX;
	localparam logic [pel_pkg::COORD_W-1:0] C_MAX = pel_pkg::COORD_W'(pel_pkg::GRID_DIM - 1);

	// Step one coordinate on the torus.
	function automatic logic [pel_pkg::COORD_W-1:0] wrap_step(
		input logic [pel_pkg::COORD_W-1:0] p, input int d);
		return (d < 0) ? ((p == '0) ? C_MAX : p - 1'b1)
			: (d > 0) ? ((p == C_MAX) ? '0 : p + 1'b1) : p;
	endfunction

	function automatic logic [pel_pkg::LAT_AW-1:0] lat_addr(
		input logic [pel_pkg::COORD_W-1:0] x, input logic [pel_pkg::COORD_W-1:0] y);
		return pel_pkg::LAT_AW'(pel_pkg::LAT_AW'(y) * pel_pkg::LAT_AW'(pel_pkg::GRID_DIM)
			+ pel_pkg::LAT_AW'(x));
	endfunction

	// Configuration registers.
	logic [12:0] target_q;
	logic [8:0]  cells_q;

	pel_pkg::state_t state_q, state_d;

	// Memories.
	logic [7:0]              lat_mem [pel_pkg::LAT_DEPTH];
	pel_pkg::cell_rec_t      cell_mem [pel_pkg::MAX_CELLS];
	logic [7:0]              lat_rd_q;
	pel_pkg::cell_rec_t      cell_rd_q;

	// Sequencer registers.
	logic [pel_pkg::CLR_W-1:0]   clr_q;
	logic [3:0]                  nb_q;
	logic [pel_pkg::CELL_AW-1:0] rec_q;
	logic [pel_pkg::COORD_W-1:0] cx_q, cy_q;
	logic                        total_q;

	// Pair pipeline.
	logic       rd_s1, centre_s1, last_s1, last_s2;
	logic [7:0] centre_q;
	logic       centre_ok_q;
	logic [3:0] count_q;

	// Area pipeline.
	logic        ar_s1, ar_s2, ar_s3;
	logic        arl_s1, arl_s2, arl_s3;
	logic [25:0] sq_s2;
	logic [15:0] w_s2;
	logic [41:0] prod_s3;

	logic signed [pel_pkg::ACC_W-1:0] acc_q;
	logic                             out_valid_q;
	logic signed [51:0]               energy_q;

	// Combinational signals.
	logic                        in_xfer;
	pel_pkg::op_t                op;
	logic [pel_pkg::COORD_W-1:0] in_x, in_y;
	logic [2:0]                  nbk;
	logic [pel_pkg::LAT_AW-1:0]  lat_rd_addr;
	logic [pel_pkg::CNT_W-1:0]   n_lim;
	logic                        site_last, rec_last;
	logic                        cell_rd_en;
	logic [pel_pkg::CELL_AW-1:0] cell_rd_addr;
	logic                        cell_wr_ok;
	logic [31:0]                 idx_ext, id_ext;
	logic signed [15:0]          alpha;
	logic signed [20:0]          pair_prod;
	logic signed [pel_pkg::ACC_W-1:0] pair_term;
	logic signed [13:0]          diff;
	logic signed [27:0]          sq_full;
	logic                        out_load;

	assign op       = pel_pkg::op_t'(operation);
	assign in_stall = (state_q != pel_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign in_x     = pel_pkg::COORD_W'(32'(pos_x) % pel_pkg::GRID_DIM);
	assign in_y     = pel_pkg::COORD_W'(32'(pos_y) % pel_pkg::GRID_DIM);
	assign nbk      = 3'(nb_q - 4'd1);
	assign idx_ext  = 32'(cell_index);
	assign id_ext   = 32'(lat_rd_q);
	assign cell_wr_ok = idx_ext < pel_pkg::MAX_CELLS;

	assign n_lim = (32'(cells_q) > pel_pkg::MAX_CELLS)
		? pel_pkg::CNT_W'(pel_pkg::MAX_CELLS) : pel_pkg::CNT_W'(cells_q);
	assign site_last = (cx_q == C_MAX) && (cy_q == C_MAX);
	assign rec_last  = (pel_pkg::CNT_W'(rec_q) + 1'b1) == n_lim;

	// Centre first, then the eight neighbours.
	always_comb begin
		if (nb_q == 4'd0) begin
			lat_rd_addr = lat_addr(cx_q, cy_q);
		end else begin
			lat_rd_addr = lat_addr(wrap_step(cx_q, pel_pkg::MOORE_DX[nbk]),
				wrap_step(cy_q, pel_pkg::MOORE_DY[nbk]));
		end
	end

	// The cell port serves the centre's alpha, then the area walk.
	always_comb begin
		cell_rd_en   = 1'b0;
		cell_rd_addr = rec_q;
		if (rd_s1 && centre_s1) begin
			cell_rd_en   = 1'b1;
			cell_rd_addr = id_ext[pel_pkg::CELL_AW-1:0];
		end else if (state_q == pel_pkg::ST_AREA) begin
			cell_rd_en = 1'b1;
		end
	end

	assign alpha     = centre_ok_q ? cell_rd_q.adhesion : 16'sd0;
	assign pair_prod = alpha * $signed({1'b0, count_q});
	assign pair_term = total_q ? pel_pkg::ACC_W'(pair_prod)
		: (pel_pkg::ACC_W'(pair_prod) <<< 1);

	assign diff    = $signed({1'b0, cell_rd_q.size}) - $signed({1'b0, target_q});
	assign sq_full = diff * diff;

	assign out_load = (state_q == pel_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pel_pkg::ST_CLEAR: begin
				if (clr_q == pel_pkg::CLR_W'(pel_pkg::CLR_DEPTH - 1)) state_d = pel_pkg::ST_IDLE;
			end
			pel_pkg::ST_IDLE: begin
				if (in_xfer && (op == pel_pkg::OP_LOCAL || op == pel_pkg::OP_TOTAL))
					state_d = pel_pkg::ST_PAIR;
			end
			pel_pkg::ST_PAIR: begin
				if (nb_q == 4'd8) state_d = pel_pkg::ST_PAIR_WAIT;
			end
			pel_pkg::ST_PAIR_WAIT: begin
				if (last_s2) begin
					if (total_q && !site_last) state_d = pel_pkg::ST_PAIR;
					else if (n_lim == '0)      state_d = pel_pkg::ST_DONE;
					else                       state_d = pel_pkg::ST_AREA;
				end
			end
			pel_pkg::ST_AREA: begin
				if (rec_last) state_d = pel_pkg::ST_AREA_WAIT;
			end
			pel_pkg::ST_AREA_WAIT: begin
				if (arl_s3) state_d = pel_pkg::ST_DONE;
			end
			pel_pkg::ST_DONE: begin
				if (out_load) state_d = pel_pkg::ST_IDLE;
			end
			default: state_d = pel_pkg::ST_CLEAR;
		endcase
	end

	// Memory ports: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (state_q == pel_pkg::ST_CLEAR) begin
			lat_mem[clr_q[pel_pkg::LAT_AW-1:0]] <= '0;
		end else if (in_xfer && op == pel_pkg::OP_SITE_WR) begin
			lat_mem[lat_addr(in_x, in_y)] <= cell_index;
		end
		if (state_q == pel_pkg::ST_PAIR) lat_rd_q <= lat_mem[lat_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == pel_pkg::ST_CLEAR) begin
			if (32'(clr_q) < pel_pkg::MAX_CELLS) cell_mem[clr_q[pel_pkg::CELL_AW-1:0]] <= '0;
		end else if (in_xfer && op == pel_pkg::OP_CELL_WR && cell_wr_ok) begin
			cell_mem[idx_ext[pel_pkg::CELL_AW-1:0]] <= '{adhesion, area_weight, cell_area};
		end
		if (cell_rd_en) cell_rd_q <= cell_mem[cell_rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pel_pkg::ST_CLEAR;
			target_q    <= 13'd16;
			cells_q     <= '0;
			clr_q       <= '0;
			nb_q        <= '0;
			rec_q       <= '0;
			rd_s1       <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			ar_s1       <= 1'b0;
			ar_s2       <= 1'b0;
			ar_s3       <= 1'b0;
			arl_s1      <= 1'b0;
			arl_s2      <= 1'b0;
			arl_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (pel_pkg::reg_t'(cfg_index))
					pel_pkg::REG_TARGET_AREA:  target_q <= cfg_data;
					pel_pkg::REG_CELLS_IN_USE: cells_q  <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (state_q == pel_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;

			// Advance the neighbour counter; rewind it for the next site.
			if (state_q == pel_pkg::ST_PAIR) nb_q <= (nb_q == 4'd8) ? '0 : nb_q + 1'b1;

			if (state_q == pel_pkg::ST_AREA) rec_q <= rec_q + 1'b1;
			else                             rec_q <= '0;

			rd_s1   <= (state_q == pel_pkg::ST_PAIR);
			last_s1 <= (state_q == pel_pkg::ST_PAIR) && (nb_q == 4'd8);
			last_s2 <= rd_s1 && last_s1;

			ar_s1  <= (state_q == pel_pkg::ST_AREA);
			arl_s1 <= (state_q == pel_pkg::ST_AREA) && rec_last;
			ar_s2  <= ar_s1;
			arl_s2 <= arl_s1;
			ar_s3  <= ar_s2;
			arl_s3 <= arl_s2;

			if (out_load)                     out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		centre_s1 <= (state_q == pel_pkg::ST_PAIR) && (nb_q == 4'd0);

		if (in_xfer) begin
			cx_q    <= (op == pel_pkg::OP_TOTAL) ? '0 : in_x;
			cy_q    <= (op == pel_pkg::OP_TOTAL) ? '0 : in_y;
			total_q <= (op == pel_pkg::OP_TOTAL);
			acc_q   <= '0;
		end else begin
			if (state_q == pel_pkg::ST_PAIR_WAIT && last_s2) begin
				if (cx_q == C_MAX) begin
					cx_q <= '0;
					cy_q <= cy_q + 1'b1;
				end else begin
					cx_q <= cx_q + 1'b1;
				end
			end
			if (last_s2) acc_q <= acc_q + pair_term;
			else if (ar_s3) acc_q <= acc_q + pel_pkg::ACC_W'({prod_s3, 1'b0});
		end

		if (rd_s1) begin
			if (centre_s1) begin
				centre_q    <= lat_rd_q;
				centre_ok_q <= id_ext < pel_pkg::MAX_CELLS;
				count_q     <= '0;
			end else if (lat_rd_q != centre_q) begin
				count_q <= count_q + 1'b1;
			end
		end

		// Square, then weight.
		sq_s2   <= sq_full[25:0];
		w_s2    <= cell_rd_q.weight;
		prod_s3 <= 42'(w_s2) * 42'(sq_s2);

		if (out_load) begin
			if (acc_q > E_MAX)      energy_q <= E_MAX[pel_pkg::E_W-1:0];
			else if (acc_q < E_MIN) energy_q <= E_MIN[pel_pkg::E_W-1:0];
			else                    energy_q <= acc_q[pel_pkg::E_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign energy    = energy_q;

endmodule

@@ hdl/pel_checker.sv @@
// Port-level checks for the lattice energy engine, bound to the top level.
// Depends on pel_pkg.
module pel_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         operation,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [51:0] energy
);

	logic in_xfer, is_query;

	assign in_xfer  = in_valid && !in_stall;
	assign is_query = (operation == pel_pkg::OP_LOCAL) || (operation == pel_pkg::OP_TOTAL);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(energy))
		else $error("result changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && is_query |=> in_stall)
		else $error("query did not hold the input");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !is_query |=> !in_stall)
		else $error("write held the input");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule

bind potts_lattice_energy pel_checker u_pel_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.operation (operation),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.energy    (energy)
);
